@@ rtl/core/prc_pkg.sv @@
package prc_pkg;

  // guard fraction bits carried below the integer part of x and y
  localparam int GUARD = 16;

  // width of the internal binary angle, one full turn is 2^ANGLE_W
  localparam int ANGLE_W = 32;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN_NEG = 32'sh8000_0000;

  // operation selector codes
  localparam logic FUNC_TO_POLAR = 1'b0;
  localparam logic FUNC_TO_RECT  = 1'b1;

  // atan(2^-i) in binary angle units
  localparam logic [ANGLE_W-1:0] ATAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // control bits that travel with each beat through the pipe
  typedef struct packed {
    logic func;  // operation selector
    logic spec;  // y zero in vectoring mode, data held through the cells
  } prc_ctl_t;

  // reciprocal of the cordic gain in q32, evaluated at elaboration only
  function automatic logic [31:0] inv_gain(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] rem;
    logic [63:0] q;
    int i;
    p = 64'd1 << 62;
    for (i = 0; i < n; i++) p = p + (p >> (2 * i));
    // integer square root, q62 down to q31
    v = p;
    res = 64'd0;
    b = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    // restoring long division of 2^63 by the root
    rem = 64'd0;
    q = 64'd0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], (i == 63)};
      if (rem >= res) begin
        rem = rem - res;
        q[i] = 1'b1;
      end
    end
    return q[31:0];
  endfunction

endpackage

@@ rtl/core/prc_prep.sv @@
module prc_prep #(
  parameter int DATA_WIDTH = 16,
  parameter int XW = 35
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic signed [DATA_WIDTH-1:0] first_in,
  input  logic signed [DATA_WIDTH-1:0] second_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output prc_pkg::prc_ctl_t            out_ctl,
  output logic signed [XW-1:0]         out_x,
  output logic signed [XW-1:0]         out_y,
  output logic signed [prc_pkg::ANGLE_W-1:0] out_z
);
  import prc_pkg::*;

  localparam int SH = ANGLE_W - DATA_WIDTH;

  logic signed [XW-1:0]      xa;
  logic signed [XW-1:0]      yb;
  logic signed [ANGLE_W-1:0] zb;
  logic signed [XW-1:0]      x_next;
  logic signed [XW-1:0]      y_next;
  logic signed [ANGLE_W-1:0] z_next;
  prc_ctl_t                  ctl_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xa = XW'(first_in) <<< GUARD;
    yb = XW'(second_in) <<< GUARD;
    zb = ANGLE_W'(second_in) <<< SH;
    ctl_next.func = func;
    ctl_next.spec = 1'b0;
    x_next = xa;
    y_next = yb;
    z_next = '0;
    if (func == FUNC_TO_POLAR) begin
      if (second_in == '0) begin
        // on the x axis: magnitude is |x|, angle 0 or -pi
        ctl_next.spec = 1'b1;
        y_next = '0;
        if (xa < 0) begin
          x_next = -xa;
          z_next = HALF_TURN_NEG;
        end
      end else if (xa < 0) begin
        // fold the left half plane by a quarter turn
        if (yb > 0) begin
          x_next = yb;
          y_next = -xa;
          z_next = QUARTER_TURN;
        end else begin
          x_next = -yb;
          y_next = xa;
          z_next = -QUARTER_TURN;
        end
      end
    end else begin
      z_next = zb;
      if (zb > QUARTER_TURN) begin
        x_next = '0;
        y_next = xa;
        z_next = zb - QUARTER_TURN;
      end else if (zb < -QUARTER_TURN) begin
        x_next = '0;
        y_next = -xa;
        z_next = zb + QUARTER_TURN;
      end else begin
        y_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctl <= ctl_next;
      out_x   <= x_next;
      out_y   <= y_next;
      out_z   <= z_next;
    end
  end

endmodule

@@ rtl/core/prc_cell.sv @@
module prc_cell #(
  parameter int XW = 35,
  parameter int STAGE = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  prc_pkg::prc_ctl_t                  in_ctl,
  input  logic signed [XW-1:0]               in_x,
  input  logic signed [XW-1:0]               in_y,
  input  logic signed [prc_pkg::ANGLE_W-1:0] in_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output prc_pkg::prc_ctl_t                  out_ctl,
  output logic signed [XW-1:0]               out_x,
  output logic signed [XW-1:0]               out_y,
  output logic signed [prc_pkg::ANGLE_W-1:0] out_z
);
  import prc_pkg::*;

  localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ATAN[STAGE];

  logic                      cw;
  logic signed [XW-1:0]      xs;
  logic signed [XW-1:0]      ys;
  logic signed [XW-1:0]      x_next;
  logic signed [XW-1:0]      y_next;
  logic signed [ANGLE_W-1:0] z_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    // vectoring drives y to zero, rotation drives z to zero
    if (in_ctl.func == FUNC_TO_RECT) begin
      cw = in_z < 0;
    end else begin
      cw = in_y > 0;
    end
    if (in_ctl.spec) begin
      x_next = in_x;
      y_next = in_y;
      z_next = in_z;
    end else if (cw) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + STEP_ANGLE;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctl <= in_ctl;
      out_x   <= x_next;
      out_y   <= y_next;
      out_z   <= z_next;
    end
  end

endmodule

@@ rtl/core/prc_scale.sv @@
module prc_scale #(
  parameter int XW = 35,
  parameter logic [31:0] INV_GAIN = 32'h9B74EDA8,
  localparam int MAGW = (XW > 32) ? XW : 33,
  localparam int RW = MAGW + 1 - prc_pkg::GUARD
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic signed [XW-1:0] v,
  input  logic                 bypass,
  output logic [RW-1:0]        mag,
  output logic                 neg
);
  import prc_pkg::*;

  localparam int TW = MAGW + 1;
  localparam logic [TW-1:0] ROUND_HALF = TW'(1) << (GUARD - 1);

  logic signed [MAGW-1:0] vx;
  logic [MAGW-1:0]        mag_abs;
  logic [MAGW-1:0]        mag1;
  logic                   neg1;
  logic                   byp1;
  logic [MAGW-1:0]        phi;
  logic [63:0]            plo;
  logic [RW-1:0]          trunc2;
  logic                   neg2;
  logic                   byp2;
  logic [TW-1:0]          sum;

  always_comb begin
    vx = MAGW'(v);
    mag_abs = vx[MAGW-1] ? MAGW'(-vx) : MAGW'(vx);
    // (hi * k) + ((lo * k) >> 32) is exactly floor(mag * k / 2^32)
    sum = TW'(phi) + TW'(plo[63:32]) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag1 <= mag_abs;
      neg1 <= v[XW-1];
      byp1 <= bypass;
    end
    if (en[1]) begin
      phi    <= MAGW'(mag1[MAGW-1:32]) * MAGW'(INV_GAIN);
      plo    <= 64'(mag1[31:0]) * 64'(INV_GAIN);
      trunc2 <= RW'(mag1 >> GUARD);
      neg2   <= neg1;
      byp2   <= byp1;
    end
    if (en[2]) begin
      mag <= byp2 ? trunc2 : RW'(sum >> GUARD);
      neg <= neg2;
    end
  end

endmodule

@@ rtl/core/prc_comp.sv @@
module prc_comp #(
  parameter int DATA_WIDTH = 16,
  parameter int XW = 35,
  parameter logic [31:0] INV_GAIN = 32'h9B74EDA8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  prc_pkg::prc_ctl_t                  in_ctl,
  input  logic signed [XW-1:0]               in_x,
  input  logic signed [XW-1:0]               in_y,
  input  logic signed [prc_pkg::ANGLE_W-1:0] in_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_WIDTH:0]                first_out,
  output logic [DATA_WIDTH-1:0]              second_out
);
  import prc_pkg::*;

  localparam int MAGW = (XW > 32) ? XW : 33;
  localparam int RW = MAGW + 1 - GUARD;
  localparam int SH = ANGLE_W - DATA_WIDTH;
  localparam logic [ANGLE_W-1:0] ZHALF = (ANGLE_W'(1) << SH) >> 1;
  localparam logic [RW-1:0] LIM_FULL = (RW'(1) << DATA_WIDTH) - RW'(1);
  localparam logic [RW-1:0] LIM_HALF = (RW'(1) << (DATA_WIDTH - 1)) - RW'(1);
  localparam logic [RW:0]   ONE_W = (RW+1)'(1);

  logic [3:0]            vld;
  logic [3:0]            rdy;
  logic [2:0]            func_p;
  logic [DATA_WIDTH-1:0] ang [3];
  logic [ANGLE_W-1:0]    zsum;
  logic [RW-1:0]         mag_x;
  logic [RW-1:0]         mag_y;
  logic                  neg_x;
  logic                  neg_y;
  logic [RW:0]           sat_x;
  logic [RW:0]           sat_y;
  logic [RW-1:0]         lim_x;

  function automatic logic [RW:0] clip(input logic [RW-1:0] m, input logic n,
                                       input logic [RW-1:0] lim);
    logic [RW:0] hi;
    hi = {1'b0, lim};
    if (!n) begin
      clip = ({1'b0, m} > hi) ? hi : {1'b0, m};
    end else begin
      clip = ({1'b0, m} > hi + ONE_W) ? -(hi + ONE_W) : -{1'b0, m};
    end
  endfunction

  always_comb begin
    rdy[3] = !vld[3] || out_ready;
    for (int k = 2; k >= 0; k--) rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // binary angle rounded half up to the output width
  assign zsum = in_z + ZHALF;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      func_p[0] <= in_ctl.func;
      ang[0]    <= zsum[ANGLE_W-1:SH];
    end
    for (int k = 1; k < 3; k++) begin
      if (rdy[k]) begin
        func_p[k] <= func_p[k-1];
        ang[k]    <= ang[k-1];
      end
    end
  end

  prc_scale #(
    .XW       (XW),
    .INV_GAIN (INV_GAIN)
  ) u_scale_x (
    .clk    (clk),
    .en     (rdy[2:0]),
    .v      (in_x),
    .bypass (in_ctl.spec),
    .mag    (mag_x),
    .neg    (neg_x)
  );

  prc_scale #(
    .XW       (XW),
    .INV_GAIN (INV_GAIN)
  ) u_scale_y (
    .clk    (clk),
    .en     (rdy[2:0]),
    .v      (in_y),
    .bypass (1'b0),
    .mag    (mag_y),
    .neg    (neg_y)
  );

  always_comb begin
    lim_x = (func_p[2] == FUNC_TO_RECT) ? LIM_HALF : LIM_FULL;
    sat_x = clip(mag_x, neg_x, lim_x);
    sat_y = clip(mag_y, neg_y, LIM_HALF);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      first_out <= sat_x[DATA_WIDTH:0];
      if (func_p[2] == FUNC_TO_RECT) begin
        second_out <= sat_y[DATA_WIDTH-1:0];
      end else begin
        second_out <= ang[2];
      end
    end
  end

endmodule

@@ rtl/core/polar_rectangular_converter.sv @@
// pipeline: an input beat passes one pre-rotation stage, one cell per iteration
//   and four gain stages on the way to its result beat
// throughput: one beat per cycle while the output is not stalled, each cordic iteration is its own cell
// stalls on the output side fill empty stages before the input is held
// reset: synchronous, active high, clears the valid bits only
module polar_rectangular_converter #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16,
  localparam int IN_TW = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((2 * DATA_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,  // first_in, second_in
  input  logic              s_tuser,  // func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata   // first_out, second_out
);
  import prc_pkg::*;

  // x and y carry the guard bits plus headroom for gain and the diagonal
  localparam int XW = DATA_WIDTH + GUARD + 3;
  localparam logic [31:0] INV_GAIN = inv_gain(ITERATIONS);

  // cell chain, index 0 is the pre-rotation stage output
  logic                      valid_c [ITERATIONS+1];
  logic                      ready_c [ITERATIONS+1];
  prc_ctl_t                  ctl_c   [ITERATIONS+1];
  logic signed [XW-1:0]      x_c     [ITERATIONS+1];
  logic signed [XW-1:0]      y_c     [ITERATIONS+1];
  logic signed [ANGLE_W-1:0] z_c     [ITERATIONS+1];

  logic [DATA_WIDTH:0]   first_out;
  logic [DATA_WIDTH-1:0] second_out;

  // folds the input into the right half plane, or the quarter turn for rotation
  prc_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser),
    .first_in  (s_tdata[DATA_WIDTH-1:0]),
    .second_in (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid (valid_c[0]),
    .out_ready (ready_c[0]),
    .out_ctl   (ctl_c[0]),
    .out_x     (x_c[0]),
    .out_y     (y_c[0]),
    .out_z     (z_c[0])
  );

  // one micro-rotation per cell, each with its own valid bit
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    prc_cell #(
      .XW    (XW),
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[i]),
      .in_ready  (ready_c[i]),
      .in_ctl    (ctl_c[i]),
      .in_x      (x_c[i]),
      .in_y      (y_c[i]),
      .in_z      (z_c[i]),
      .out_valid (valid_c[i+1]),
      .out_ready (ready_c[i+1]),
      .out_ctl   (ctl_c[i+1]),
      .out_x     (x_c[i+1]),
      .out_y     (y_c[i+1]),
      .out_z     (z_c[i+1])
    );
  end

  // gain removal, rounding, saturation; its last stage is the output register
  prc_comp #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW),
    .INV_GAIN   (INV_GAIN)
  ) u_comp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (valid_c[ITERATIONS]),
    .in_ready   (ready_c[ITERATIONS]),
    .in_ctl     (ctl_c[ITERATIONS]),
    .in_x       (x_c[ITERATIONS]),
    .in_y       (y_c[ITERATIONS]),
    .in_z       (z_c[ITERATIONS]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .first_out  (first_out),
    .second_out (second_out)
  );

  // result beat: first_out low, second_out above, zero padded to bytes
  assign m_tdata = OUT_TW'({second_out, first_out});

`ifndef SYNTHESIS
  // the input is held back only when every stage is full and the output stalls
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while the pipe has room");

  // an accepted beat always lands in the pre-rotation stage
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> valid_c[0])
    else $error("accepted beat lost at the pre-rotation stage");

  // the held axis case only arises in vectoring mode
  assert property (@(posedge clk) disable iff (rst)
    valid_c[0] && ctl_c[0].spec |-> ctl_c[0].func == FUNC_TO_POLAR)
    else $error("axis bypass flagged in rotation mode");

  // vectoring keeps x in the right half plane to the end of the chain
  assert property (@(posedge clk) disable iff (rst)
    valid_c[ITERATIONS] && ctl_c[ITERATIONS].func == FUNC_TO_POLAR
      |-> !x_c[ITERATIONS][XW-1])
    else $error("negative x after vectoring");

  // rotation keeps the residual angle within a quarter turn
  assert property (@(posedge clk) disable iff (rst)
    valid_c[ITERATIONS] && ctl_c[ITERATIONS].func == FUNC_TO_RECT
      |-> z_c[ITERATIONS] <= QUARTER_TURN && z_c[ITERATIONS] >= -QUARTER_TURN)
    else $error("residual angle out of range after rotation");
`endif

endmodule

@@ tb/coord_checker.sv @@
module coord_checker #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,     // first_in, second_in
  input  logic        s_tuser,     // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,     // first_out, second_out
  output int          mismatches,
  output int          outstanding
);

  import prc_pkg::*;

  typedef struct packed {
    logic signed [16:0] first_out;
    logic signed [15:0] second_out;
  } coord_t;

  coord_t      expected_coords[$];
  logic [63:0] gain_q32;

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 1/K in q32, K^2 built in q62 from the stage count
  function automatic logic [63:0] gain_recip(input int stages);
    logic [63:0] p;
    int i;
    p = 64'd1 << 62;
    for (i = 0; i < stages; i++) p = p + (p >> (2 * i));
    return (64'd1 << 63) / root_floor(p);
  endfunction

  // strip the gain, drop the guard bits, round half away from zero
  function automatic longint remove_gain(input longint v);
    logic [63:0] mag;
    logic [63:0] t;
    longint r;
    mag = (v < 0) ? -v : v;
    t = (mag >> 32) * gain_q32 + (((mag & 64'hFFFF_FFFF) * gain_q32) >> 32);
    r = (t + (64'd1 << (GUARD - 1))) >> GUARD;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic coord_t convert_coords(input logic func,
                                            input logic signed [15:0] opnd_a,
                                            input logic signed [15:0] opnd_b);
    longint a, b, x, y, z, nx, ny, o1, o2, qturn, step;
    logic [63:0] zu;
    int i;
    coord_t res;
    a = longint'(opnd_a);
    b = longint'(opnd_b);
    qturn = longint'(QUARTER_TURN);
    if (func == FUNC_TO_POLAR) begin
      if (b == 0) begin
        o1 = (a < 0) ? -a : a;
        o2 = (a < 0) ? -64'sd32768 : 64'sd0;
      end else begin
        x = a * 65536;
        y = b * 65536;
        z = 0;
        // fold the left half plane onto the right
        if (x < 0) begin
          if (y > 0) begin
            nx = y;
            ny = -x;
            z = qturn;
          end else begin
            nx = -y;
            ny = x;
            z = -qturn;
          end
          x = nx;
          y = ny;
        end
        for (i = 0; i < ITERATIONS; i++) begin
          step = longint'(ATAN[i]);
          if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z = z + step;
          end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z = z - step;
          end
          x = nx;
          y = ny;
        end
        o1 = clamp(remove_gain(x), 17);
        // round half up to 16 bits, wrapping at plus pi
        zu = z + 64'd32768;
        o2 = longint'(signed'(zu[31:16]));
      end
    end else begin
      z = b * 65536;
      if (z > qturn) begin
        x = 0;
        y = a;
        z = z - qturn;
      end else if (z < -qturn) begin
        x = 0;
        y = -a;
        z = z + qturn;
      end else begin
        x = a;
        y = 0;
      end
      x = x * 65536;
      y = y * 65536;
      for (i = 0; i < ITERATIONS; i++) begin
        step = longint'(ATAN[i]);
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - step;
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + step;
        end
        x = nx;
        y = ny;
      end
      o1 = clamp(remove_gain(x), 16);
      o2 = clamp(remove_gain(y), 16);
    end
    res.first_out = o1[16:0];
    res.second_out = o2[15:0];
    return res;
  endfunction

  initial gain_q32 = gain_recip(ITERATIONS);

  always @(posedge clk) begin
    coord_t got;
    coord_t want;
    coord_t pred;
    int errs;
    errs = 0;
    if (!rst) begin
      // compare the result beat before taking the new input beat
      if (m_tvalid && m_tready) begin
        got.first_out = m_tdata[16:0];
        got.second_out = m_tdata[32:17];
        if (expected_coords.size() == 0) begin
          $error("result beat with no expectation: first_out %0d second_out %0d",
                 got.first_out, got.second_out);
          errs++;
        end else begin
          want = expected_coords.pop_front();
          if (got.first_out !== want.first_out) begin
            $error("first_out: expected %0d, actual %0d", want.first_out, got.first_out);
            errs++;
          end
          if (got.second_out !== want.second_out) begin
            $error("second_out: expected %0d, actual %0d", want.second_out, got.second_out);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pred = convert_coords(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        expected_coords = {expected_coords, pred};
      end
    end
    mismatches <= mismatches + errs;
    outstanding <= expected_coords.size();
  end

endmodule

@@ tb/testbench.sv @@
module testbench;

  import prc_pkg::*;

  localparam int DATA_W = 16;
  localparam int ITERS = 16;
  // input beat to result beat; the final wait adds a margin for the drain
  localparam int LATENCY = ITERS + 5;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // first_in, second_in
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // first_out, second_out
  int          mismatches;
  int          outstanding;
  bit          no_idle;

  polar_rectangular_converter #(
    .DATA_WIDTH (DATA_W),
    .ITERATIONS (ITERS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  coord_checker #(
    .ITERATIONS (ITERS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operand mix: full range, small values, corners, zero, tiny offsets
  function automatic int draw_operand(input int kind);
    case (kind)
      0: return $urandom_range(0, 64) - 32;
      1: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
      2: return 0;
      3: return $urandom_range(1, 3) * (($urandom_range(0, 1) == 1) ? 1 : -1);
      default: return int'($urandom());
    endcase
  endfunction

  // one input beat, driven after the falling edge and held until the converter accepts it
  task automatic send_sample(input logic func, input int a, input int b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = func;
    s_tdata = {b[15:0], a[15:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input side until every result beat is back
  task automatic drain_pipe();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (outstanding == 0);
  endtask

  // result side back pressure, driven on the falling edge
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!no_idle) stall = pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic func;
    int blk;
    int n;
    int a;
    int b;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    no_idle = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // vectoring with y zero: exact magnitude, angle 0 or minus pi
    send_sample(FUNC_TO_POLAR, 0, 0);
    send_sample(FUNC_TO_POLAR, 5, 0);
    send_sample(FUNC_TO_POLAR, -5, 0);
    send_sample(FUNC_TO_POLAR, -32768, 0);
    send_sample(FUNC_TO_POLAR, 32767, 0);
    // axes and corners, the largest magnitude at the far corner
    send_sample(FUNC_TO_POLAR, 0, 1);
    send_sample(FUNC_TO_POLAR, 0, -32768);
    send_sample(FUNC_TO_POLAR, -32768, -32768);
    send_sample(FUNC_TO_POLAR, 32767, 32767);
    send_sample(FUNC_TO_POLAR, -32768, 32767);
    send_sample(FUNC_TO_POLAR, 32767, -32768);
    // just above and below the negative x axis, angle wraps to minus pi
    send_sample(FUNC_TO_POLAR, -32768, 1);
    send_sample(FUNC_TO_POLAR, -32768, -1);
    // rotation: quadrant boundaries and the half turn
    send_sample(FUNC_TO_RECT, 32767, 0);
    send_sample(FUNC_TO_RECT, 32767, -32768);
    send_sample(FUNC_TO_RECT, 32767, 16384);
    send_sample(FUNC_TO_RECT, 32767, -16384);
    send_sample(FUNC_TO_RECT, 32767, 32767);
    send_sample(FUNC_TO_RECT, 32767, 8192);
    // negative radius is a signed factor, saturating at the extremes
    send_sample(FUNC_TO_RECT, -32768, 0);
    send_sample(FUNC_TO_RECT, -32768, -32768);
    send_sample(FUNC_TO_RECT, -32768, 8192);
    send_sample(FUNC_TO_RECT, 0, 12345);
    send_sample(FUNC_TO_RECT, 1, -1);
    drain_pipe();

    // random part in blocks, some without any idling, some drained at the end
    for (blk = 0; blk < 18; blk++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 100; n++) begin
        func = 1'($urandom_range(0, 1));
        a = draw_operand($urandom_range(0, 9));
        b = draw_operand($urandom_range(0, 9));
        send_sample(func, a, b);
      end
      if ($urandom_range(0, 2) == 0) drain_pipe();
    end
    no_idle = 1'b0;

    drain_pipe();
    repeat (LATENCY + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
